### src/rpn_pkg.sv
// rpn_pkg: shared constants, status codes and the controller/datapath command
// and status structs for the reverse Polish evaluator
// no dependencies

package rpn_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int STEP_W      = $clog2(DATA_W);

	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_MUL   = 8'h2A;
	localparam logic [7:0] CHR_DIV   = 8'h2F;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_UNDER  = 3'd1,
		ST_DIVZ   = 3'd2,
		ST_OVER   = 3'd3,
		ST_NOTONE = 3'd4
	} rpn_status_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic load;
		logic digit;
		logic flush;
		logic set_under;
		logic set_divz;
		logic rd_top;
		logic rd_next;
		logic rd_base;
		logic cap_rhs;
		logic exec;
		logic div_start;
		logic div_write;
		logic emit;
	} rpn_cmd_t;

	// flags back from the datapath
	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic is_div;
		logic last;
		logic err_any;
		logic cnt_lt2;
		logic rhs_zero;
		logic div_done;
		logic out_free;
	} rpn_flags_t;

endpackage

### src/rpn_in_if.sv
// rpn_in_if: expression byte channel with valid/ready handshake
// no dependencies

interface rpn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_expr;

	modport source (output valid, output in_byte, output end_of_expr, input ready);
	modport sink   (input valid, input in_byte, input end_of_expr, output ready);
endinterface

### src/rpn_out_if.sv
// rpn_out_if: result channel carrying value and status, valid/ready handshake
// no dependencies

interface rpn_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [2:0]         status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

### src/rpn_stack_evaluator_top.sv
// Reverse Polish evaluator: takes one ASCII byte per transfer on in_ch and,
// for the byte marked end_of_expr, gives one value/status transfer on out_ch.
// Digits pass through decode and finish; other bytes flush the pending number, and
// operators then check the stack, read both operands and execute, '/' in the 32-step
// shift-subtract divider; an operator meeting an earlier error or too few values ends
// at the check, a zero divisor at execute. The expression's last byte then reads the
// stack base and loads the result register, waiting only while an earlier result is
// unclaimed. The result register lets the next expression start while a result waits.
// Depends on rpn_pkg, rpn_in_if, rpn_out_if, rpn_ctrl, rpn_datapath.

module rpn_stack_evaluator_top
	import rpn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	rpn_in_if.sink   in_ch,
	rpn_out_if.source out_ch
);

	rpn_cmd_t   cmd;
	rpn_flags_t flags;
	logic [31:0] value_bits;

	rpn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.flags    (flags),
		.cmd      (cmd)
	);

	rpn_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.flags       (flags),
		.in_byte     (in_ch.in_byte),
		.end_of_expr (in_ch.end_of_expr),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_value   (value_bits),
		.out_status  (out_ch.status)
	);

	assign out_ch.value = $signed(value_bits);

endmodule

### src/rpn_divider.sv
// rpn_divider: iterative signed 32-bit divider, one quotient bit per cycle,
// truncating toward zero; uses rpn_pkg

module rpn_divider
	import rpn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;

	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              fits;

	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// magnitudes go in, sign is put back at the end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

### src/rpn_datapath.sv
// rpn_datapath: byte register, number accumulator, value stack memory, alu,
// error register and result register; uses rpn_pkg and rpn_divider

module rpn_datapath
	import rpn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  rpn_cmd_t     cmd,
	output rpn_flags_t   flags,
	input  logic [7:0]   in_byte,
	input  logic         end_of_expr,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [31:0]  out_value,
	output logic [2:0]   out_status
);

	logic [7:0]        byte_q;
	logic              last_q;
	logic [DATA_W-1:0] acc_q;
	logic              in_num_q;
	rpn_status_t       err_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rhs_q;
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic              out_valid_q;
	logic [DATA_W-1:0] value_q;
	rpn_status_t       status_q;

	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  cnt_m2;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              wr_en;
	logic [DATA_W-1:0] acc_next;
	logic [DATA_W-1:0] alu_res;
	logic [DATA_W-1:0] quotient;
	logic              div_done;
	logic              push_ok;
	logic              pushing;

	assign cnt_m1 = cnt_q - 1'b1;
	assign cnt_m2 = cnt_q - CNT_W'(2);

	// acc * 10 + digit, wrapping
	assign acc_next = {acc_q[DATA_W-4:0], 3'b000} + {acc_q[DATA_W-2:0], 1'b0}
	                + {{(DATA_W-4){1'b0}}, byte_q[3:0]};

	always_comb begin
		case (byte_q)
			CHR_PLUS:  alu_res = rd_q + rhs_q;
			CHR_MINUS: alu_res = rd_q - rhs_q;
			default:   alu_res = rd_q * rhs_q;
		endcase
	end

	assign pushing = cmd.flush && in_num_q && (err_q == ST_OK);
	assign push_ok = cnt_q < CNT_W'(STACK_DEPTH);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[ADDR_W-1:0];
		wr_data = acc_q;
		if (pushing && push_ok) begin
			wr_en = 1'b1;
		end else if (cmd.exec) begin
			wr_en   = 1'b1;
			wr_addr = cnt_m2[ADDR_W-1:0];
			wr_data = alu_res;
		end else if (cmd.div_write) begin
			wr_en   = 1'b1;
			wr_addr = cnt_m2[ADDR_W-1:0];
			wr_data = quotient;
		end
	end

	always_comb begin
		rd_addr = cnt_m1[ADDR_W-1:0];
		if (cmd.rd_next) begin
			rd_addr = cnt_m2[ADDR_W-1:0];
		end else if (cmd.rd_base) begin
			rd_addr = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_top || cmd.rd_next || cmd.rd_base) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= in_byte;
			last_q <= end_of_expr;
		end
		if (cmd.cap_rhs) begin
			rhs_q <= rd_q;
		end
		if (cmd.emit) begin
			value_q  <= ((err_q == ST_OK) && (cnt_q == CNT_W'(1))) ? rd_q : '0;
			status_q <= (err_q != ST_OK) ? err_q :
			            (cnt_q != CNT_W'(1)) ? ST_NOTONE : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			in_num_q    <= 1'b0;
			err_q       <= ST_OK;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				acc_q       <= '0;
				in_num_q    <= 1'b0;
				err_q       <= ST_OK;
				cnt_q       <= '0;
			end else if (cmd.digit) begin
				if (err_q == ST_OK) begin
					acc_q    <= acc_next;
					in_num_q <= 1'b1;
				end
			end else if (cmd.flush) begin
				acc_q    <= '0;
				in_num_q <= 1'b0;
				if (pushing) begin
					if (push_ok) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						err_q <= ST_OVER;
					end
				end
			end else if (cmd.set_under) begin
				err_q <= ST_UNDER;
			end else if (cmd.set_divz) begin
				err_q <= ST_DIVZ;
			end else if (cmd.exec || cmd.div_write) begin
				cnt_q <= cnt_m1;
			end
		end
	end

	rpn_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_q),
		.divisor  (rhs_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign flags.is_digit = (byte_q >= CHR_ZERO) && (byte_q <= CHR_NINE);
	assign flags.is_op    = (byte_q == CHR_PLUS) || (byte_q == CHR_MINUS)
	                     || (byte_q == CHR_MUL) || (byte_q == CHR_DIV);
	assign flags.is_div   = byte_q == CHR_DIV;
	assign flags.last     = last_q;
	assign flags.err_any  = err_q != ST_OK;
	assign flags.cnt_lt2  = cnt_q < CNT_W'(2);
	assign flags.rhs_zero = rhs_q == '0;
	assign flags.div_done = div_done;
	assign flags.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_value  = value_q;
	assign out_status = status_q;

endmodule

### src/rpn_ctrl.sv
// rpn_ctrl: sequencer for the evaluator, steps each byte through decode,
// operand reads, execution and the end-of-expression result; uses rpn_pkg

module rpn_ctrl
	import rpn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  rpn_flags_t flags,
	output rpn_cmd_t   cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DECODE = 9'b000000010,
		S_CHECK  = 9'b000000100,
		S_RD_RHS = 9'b000001000,
		S_EXEC   = 9'b000010000,
		S_DIV    = 9'b000100000,
		S_FINISH = 9'b001000000,
		S_FINAL  = 9'b010000000,
		S_EMIT   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (flags.is_digit) begin
					cmd.digit = 1'b1;
					state_d   = S_FINISH;
				end else begin
					// pending number goes on the stack before the operator
					cmd.flush = 1'b1;
					state_d   = flags.is_op ? S_CHECK : S_FINISH;
				end
			end
			S_CHECK: begin
				if (flags.err_any) begin
					state_d = S_FINISH;
				end else if (flags.cnt_lt2) begin
					cmd.set_under = 1'b1;
					state_d       = S_FINISH;
				end else begin
					cmd.rd_top = 1'b1;
					state_d    = S_RD_RHS;
				end
			end
			S_RD_RHS: begin
				cmd.cap_rhs = 1'b1;
				cmd.rd_next = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				if (!flags.is_div) begin
					cmd.exec = 1'b1;
					state_d  = S_FINISH;
				end else if (flags.rhs_zero) begin
					cmd.set_divz = 1'b1;
					state_d      = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (flags.div_done) begin
					cmd.div_write = 1'b1;
					state_d       = S_FINISH;
				end
			end
			S_FINISH: begin
				if (flags.last) begin
					cmd.flush = 1'b1;
					state_d   = S_FINAL;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FINAL: begin
				cmd.rd_base = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				// hold until the result register is free
				if (flags.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
